[rtl/mkc_pkg.sv]
package mkc_pkg;

	// Block constants
	localparam int KEY_COUNT      = 4;
	localparam int DEBOUNCE_TICKS = 4;
	localparam int COUNT_WIDTH    = 16;

	// Fixed sizes: four key slots, 16-bit threshold fields, two events per key
	localparam int SLOTS     = 4;
	localparam int FIELD_W   = 16;
	localparam int BUF_DEPTH = 2 * SLOTS;
	localparam int BUF_IDX_W = 3;
	localparam int BUF_CNT_W = 4;

	localparam logic [1:0]         KEY_LAST     = 2'(KEY_COUNT - 1);
	localparam logic [FIELD_W-1:0] DEBOUNCE_LIM = FIELD_W'(DEBOUNCE_TICKS);
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = '1;
	localparam logic [1:0]         CLICK_MAX    = 2'd3;

	// Key modes
	localparam logic [1:0] MODE_RELEASED = 2'd0;
	localparam logic [1:0] MODE_DOWN     = 2'd1;
	localparam logic [1:0] MODE_HOLD     = 2'd2;

	// Event kinds
	localparam logic [2:0] EV_HOLD    = 3'd0;
	localparam logic [2:0] EV_LONG    = 3'd1;
	localparam logic [2:0] EV_SINGLE  = 3'd2;
	localparam logic [2:0] EV_RELEASE = 3'd5;

	// Pending event codes
	localparam logic [2:0] PEND_NONE = 3'd0;
	localparam logic [2:0] PEND_HOLD = 3'd4;
	localparam logic [2:0] PEND_LONG = 3'd5;

	// Register indexes
	localparam logic [1:0] CFG_INTERVAL = 2'd0;
	localparam logic [1:0] CFG_HOLD     = 2'd1;
	localparam logic [1:0] CFG_LONG     = 2'd2;
	localparam logic [1:0] CFG_RELEASE  = 2'd3;

	typedef struct packed {
		logic [1:0] key;
		logic [2:0] kind;
		logic [2:0] rel;
	} event_t;

	typedef struct packed {
		logic [COUNT_WIDTH-1:0] down;
		logic [COUNT_WIDTH-1:0] up;
		logic [1:0]             click;
		logic [1:0]             mode;
		logic [2:0]             pend;
	} key_state_t;

	typedef struct packed {
		logic   ev0_valid;
		event_t ev0;
		logic   ev1_valid;
		event_t ev1;
	} key_events_t;

	function automatic logic [COUNT_WIDTH-1:0] sat_cnt(input logic [COUNT_WIDTH-1:0] v);
		return (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
	endfunction

	function automatic logic [1:0] sat_click(input logic [1:0] v);
		return (v == CLICK_MAX) ? CLICK_MAX : v + 1'b1;
	endfunction

endpackage

[rtl/multi_key_click_hold_classifier.sv]
// Multi-key click, hold and long-press classifier.
//
// Input channel: one request per scan tick, pressed_mask holds the pressed
// bit of every key. Output channel: one request per event, with key_index,
// event_kind, released_event and last, which marks the final event of a tick.
// A tick with no events produces no output request.
//
// One shared key update unit visits the keys one per cycle. A tick is
// accepted, then every key is scanned, then events move into the output
// register one per cycle while the output does not stall, and the sequence
// returns to idle once the buffer is seen empty; a tick has 0..8 events at four keys.
// in_stall stays high from acceptance until every event of the tick has been
// moved to the output register; the last event may still wait there while
// the next tick is scanned.
//
// The user writes configuration through cfg_we / cfg_index / cfg_data while
// idle; the block does not enforce this. Reset clears the configuration and
// key state; all keys start released. A stalled receiver holds the output
// register and the drain, which in turn holds in_stall high.
module multi_key_click_hold_classifier (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  pressed_mask,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  key_index,
	output logic [2:0]  event_kind,
	output logic [2:0]  released_event,
	output logic        last
);
	import mkc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_DRAIN = 3'b100
	} seq_state_t;

	seq_state_t  state_q;
	logic [1:0]  key_q;
	logic [3:0]  mask_q;
	logic [63:0] interval_q;
	logic [63:0] hold_q;
	logic [63:0] long_q;
	logic [3:0]  rel_en_q;
	key_state_t  keys_q [SLOTS];
	key_state_t  nxt;
	key_events_t evs;
	logic        accept;
	logic        drained;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= '0;
			hold_q <= '0;
			long_q <= '0;
			rel_en_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_INTERVAL: interval_q <= cfg_data;
				CFG_HOLD:     hold_q <= cfg_data;
				CFG_LONG:     long_q <= cfg_data;
				CFG_RELEASE:  rel_en_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	mkc_key_unit u_key (
		.pressed  (mask_q[key_q]),
		.key      (key_q),
		.cur      (keys_q[key_q]),
		.interval (interval_q[{key_q, 4'b0000} +: FIELD_W]),
		.hold     (hold_q[{key_q, 4'b0000} +: FIELD_W]),
		.lng      (long_q[{key_q, 4'b0000} +: FIELD_W]),
		.rel_en   (rel_en_q[key_q]),
		.nxt      (nxt),
		.evs      (evs)
	);

	// Sequence: accept a tick, visit each key, drain the events
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			key_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						key_q <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (key_q == KEY_LAST) begin
						state_q <= ST_DRAIN;
					end else begin
						key_q <= key_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (drained) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mask_q <= pressed_mask;
		end
	end

	// Write back the visited key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				keys_q[i] <= '{down: '0, up: '0, click: 2'd0, mode: MODE_RELEASED,
					pend: PEND_NONE};
			end
		end else if (state_q == ST_SCAN) begin
			keys_q[key_q] <= nxt;
		end
	end

	mkc_event_buf u_buf (
		.clk            (clk),
		.arst_n         (arst_n),
		.clr            (accept),
		.wr_en          (state_q == ST_SCAN),
		.evs            (evs),
		.drain_en       (state_q == ST_DRAIN),
		.drained        (drained),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.key_index      (key_index),
		.event_kind     (event_kind),
		.released_event (released_event),
		.last           (last)
	);

endmodule

[rtl/mkc_key_unit.sv]
module mkc_key_unit (
	input  logic                     pressed,
	input  logic [1:0]               key,
	input  mkc_pkg::key_state_t      cur,
	input  logic [mkc_pkg::FIELD_W-1:0] interval,
	input  logic [mkc_pkg::FIELD_W-1:0] hold,
	input  logic [mkc_pkg::FIELD_W-1:0] lng,
	input  logic                     rel_en,
	output mkc_pkg::key_state_t      nxt,
	output mkc_pkg::key_events_t     evs
);
	import mkc_pkg::*;

	logic [COUNT_WIDTH-1:0] d1;
	logic [COUNT_WIDTH-1:0] u1;
	logic [1:0]             c1;
	logic [2:0]             p1;

	// Update one key for one scan tick
	always_comb begin
		nxt = cur;
		evs = '0;
		evs.ev0.key = key;
		evs.ev1.key = key;
		d1 = sat_cnt(cur.down);
		u1 = sat_cnt(cur.up);
		c1 = cur.click;
		p1 = cur.pend;
		if (!pressed) begin
			// count a click on release after a debounced press
			if (FIELD_W'(cur.down) > DEBOUNCE_LIM && cur.mode != MODE_HOLD) begin
				c1 = sat_click(cur.click);
			end
			nxt.down = '0;
			nxt.click = c1;
			if (!(cur.mode == MODE_RELEASED && c1 == 2'd0)) begin
				nxt.up = u1;
				// report clicks once the gap has passed
				if (c1 != 2'd0 && FIELD_W'(u1) > interval) begin
					evs.ev0_valid = 1'b1;
					evs.ev0.kind = EV_SINGLE + 3'(c1 - 2'd1);
					p1 = {1'b0, c1};
					nxt.click = 2'd0;
				end
				nxt.pend = p1;
				// settle into released, handing back the pending event
				if (FIELD_W'(u1) > DEBOUNCE_LIM && (cur.mode != MODE_RELEASED || p1 != PEND_NONE)) begin
					if (p1 != PEND_NONE && rel_en) begin
						evs.ev1_valid = 1'b1;
						evs.ev1.kind = EV_RELEASE;
						evs.ev1.rel = p1;
						nxt.pend = PEND_NONE;
					end
					nxt.mode = MODE_RELEASED;
				end
			end
		end else if (cur.mode != MODE_DOWN) begin
			nxt.down = d1;
			nxt.up = '0;
			if ((hold == '0 && lng == '0) || cur.click != 2'd0) begin
				// confirm press after debounce
				if (FIELD_W'(d1) > DEBOUNCE_LIM) begin
					nxt.down = '0;
					nxt.mode = MODE_DOWN;
					nxt.click = sat_click(cur.click);
				end
			end else if (FIELD_W'(d1) >= hold && cur.mode != MODE_HOLD) begin
				nxt.mode = MODE_HOLD;
				nxt.pend = PEND_HOLD;
				evs.ev0_valid = 1'b1;
				evs.ev0.kind = EV_HOLD;
			end else if (lng != '0 && FIELD_W'(d1) >= lng) begin
				nxt.down = '0;
				nxt.mode = MODE_DOWN;
				nxt.pend = PEND_LONG;
				evs.ev0_valid = 1'b1;
				evs.ev0.kind = EV_LONG;
			end
		end
	end

endmodule

[rtl/mkc_event_buf.sv]
module mkc_event_buf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 clr,
	input  logic                 wr_en,
	input  mkc_pkg::key_events_t evs,
	input  logic                 drain_en,
	output logic                 drained,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           key_index,
	output logic [2:0]           event_kind,
	output logic [2:0]           released_event,
	output logic                 last
);
	import mkc_pkg::*;

	event_t               buf_q [BUF_DEPTH];
	logic [BUF_CNT_W-1:0] cnt_q;
	logic [BUF_CNT_W-1:0] rd_q;
	logic [BUF_CNT_W-1:0] wr1_cnt;
	logic                 load;
	logic                 out_valid_q;
	event_t               out_ev_q;
	logic                 out_last_q;

	assign wr1_cnt = cnt_q + BUF_CNT_W'(evs.ev0_valid);
	assign drained = (rd_q == cnt_q);
	assign load    = drain_en && !drained && (!out_valid_q || !out_stall);

	// Collect the events of one tick in order
	always_ff @(posedge clk) begin
		if (wr_en && evs.ev0_valid) begin
			buf_q[cnt_q[BUF_IDX_W-1:0]] <= evs.ev0;
		end
		if (wr_en && evs.ev1_valid) begin
			buf_q[wr1_cnt[BUF_IDX_W-1:0]] <= evs.ev1;
		end
	end

	// Advance write count and read pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q <= '0;
		end else if (clr) begin
			cnt_q <= '0;
			rd_q <= '0;
		end else begin
			if (wr_en) begin
				cnt_q <= wr1_cnt + BUF_CNT_W'(evs.ev1_valid);
			end
			if (load) begin
				rd_q <= rd_q + 1'b1;
			end
		end
	end

	// Hold the output request until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_ev_q <= buf_q[rd_q[BUF_IDX_W-1:0]];
			out_last_q <= (rd_q + 1'b1 == cnt_q);
		end
	end

	assign out_valid      = out_valid_q;
	assign key_index      = out_ev_q.key;
	assign event_kind     = out_ev_q.kind;
	assign released_event = out_ev_q.rel;
	assign last           = out_last_q;

endmodule

[verif/mkc_event_checker.sv]
`timescale 1ns / 1ps

module mkc_event_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [3:0]  pressed_mask,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  key_index,
	input  logic [2:0]  event_kind,
	input  logic [2:0]  released_event,
	input  logic        last,
	output int          mismatches,
	output int          outstanding,
	output int          ticks_seen,
	output int          events_seen,
	output logic [7:0]  kinds_seen
);

	import mkc_pkg::*;

	typedef struct packed {
		event_t ev;
		logic   last;
	} tick_event_t;

	// Shadow copy of the configuration registers
	logic [63:0] interval_r;
	logic [63:0] hold_r;
	logic [63:0] long_r;
	logic [3:0]  release_r;

	// Per-key shadow state
	logic [COUNT_WIDTH-1:0] down_cnt [SLOTS];
	logic [COUNT_WIDTH-1:0] up_cnt [SLOTS];
	logic [1:0]             clicks [SLOTS];
	logic [1:0]             mode [SLOTS];
	logic [2:0]             pend [SLOTS];

	tick_event_t predicted_events [$];
	tick_event_t want;

	function automatic logic [COUNT_WIDTH-1:0] bump_count(input logic [COUNT_WIDTH-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	function automatic logic [1:0] bump_click(input logic [1:0] v);
		return (v == CLICK_MAX) ? v : v + 1'b1;
	endfunction

	function automatic tick_event_t make_event(input int k, input logic [2:0] kind,
			input logic [2:0] rel);
		tick_event_t e;
		e.ev.key  = 2'(k);
		e.ev.kind = kind;
		e.ev.rel  = rel;
		e.last    = 1'b0;
		return e;
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		mismatches++;
	endtask

	// Confirm a debounced press: count one click and enter down mode
	task automatic take_press(input int k);
		if (down_cnt[k] > DEBOUNCE_LIM) begin
			down_cnt[k] = '0;
			mode[k]     = MODE_DOWN;
			clicks[k]   = bump_click(clicks[k]);
		end
	endtask

	// Advance every key by one scan tick and queue the events it raises
	task automatic classify_tick(input logic [3:0] mask);
		tick_event_t found [2*SLOTS];
		int n;
		logic [FIELD_W-1:0] gap;
		logic [FIELD_W-1:0] hold_th;
		logic [FIELD_W-1:0] long_th;
		n = 0;
		for (int k = 0; k < KEY_COUNT; k++) begin
			gap     = interval_r[FIELD_W*k +: FIELD_W];
			hold_th = hold_r[FIELD_W*k +: FIELD_W];
			long_th = long_r[FIELD_W*k +: FIELD_W];
			if (!mask[k]) begin
				// a short press that ends before hold counts as a click on release
				if (down_cnt[k] > DEBOUNCE_LIM && mode[k] != MODE_HOLD)
					clicks[k] = bump_click(clicks[k]);
				down_cnt[k] = '0;
				if (!(mode[k] == MODE_RELEASED && clicks[k] == 2'd0)) begin
					up_cnt[k] = bump_count(up_cnt[k]);
					if (clicks[k] != 2'd0 && up_cnt[k] > gap) begin
						found[n] = make_event(k, EV_SINGLE + {1'b0, clicks[k]} - 3'd1, PEND_NONE);
						n++;
						pend[k]   = {1'b0, clicks[k]};
						clicks[k] = 2'd0;
					end
					if (up_cnt[k] > DEBOUNCE_LIM &&
						(mode[k] != MODE_RELEASED || pend[k] != PEND_NONE)) begin
						if (pend[k] != PEND_NONE && release_r[k]) begin
							found[n] = make_event(k, EV_RELEASE, pend[k]);
							n++;
							pend[k] = PEND_NONE;
						end
						mode[k] = MODE_RELEASED;
					end
				end
			end else if (mode[k] != MODE_DOWN) begin
				down_cnt[k] = bump_count(down_cnt[k]);
				up_cnt[k]   = '0;
				if (hold_th == '0 && long_th == '0) begin
					take_press(k);
				end else if (clicks[k] == 2'd0) begin
					if (down_cnt[k] >= hold_th && mode[k] != MODE_HOLD) begin
						mode[k]  = MODE_HOLD;
						pend[k]  = PEND_HOLD;
						found[n] = make_event(k, EV_HOLD, PEND_NONE);
						n++;
					end else if (long_th != '0 && down_cnt[k] >= long_th) begin
						down_cnt[k] = '0;
						mode[k]     = MODE_DOWN;
						pend[k]     = PEND_LONG;
						found[n]    = make_event(k, EV_LONG, PEND_NONE);
						n++;
					end
				end else begin
					take_press(k);
				end
			end
		end
		for (int i = 0; i < n; i++) begin
			if (i == n - 1)
				found[i].last = 1'b1;
			predicted_events.push_back(found[i]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_r  = '0;
			hold_r      = '0;
			long_r      = '0;
			release_r   = '0;
			for (int k = 0; k < SLOTS; k++) begin
				down_cnt[k] = '0;
				up_cnt[k]   = '0;
				clicks[k]   = 2'd0;
				mode[k]     = MODE_RELEASED;
				pend[k]     = PEND_NONE;
			end
			predicted_events.delete();
			mismatches  = 0;
			ticks_seen  = 0;
			events_seen = 0;
			kinds_seen  = '0;
		end else begin
			// track register writes
			if (cfg_we) begin
				case (cfg_index)
					CFG_INTERVAL: interval_r = cfg_data;
					CFG_HOLD:     hold_r     = cfg_data;
					CFG_LONG:     long_r     = cfg_data;
					CFG_RELEASE:  release_r  = cfg_data[3:0];
					default:      ;
				endcase
			end

			// compare each accepted event against the oldest prediction
			if (out_valid && !out_stall) begin
				events_seen++;
				kinds_seen[event_kind] = 1'b1;
				if (predicted_events.size() == 0) begin
					report_mismatch($sformatf("unpredicted event key %0d kind %0d rel %0d last %0d",
						key_index, event_kind, released_event, last));
				end else begin
					want = predicted_events.pop_front();
					if (key_index !== want.ev.key || event_kind !== want.ev.kind ||
						released_event !== want.ev.rel || last !== want.last)
						report_mismatch($sformatf(
							"got key %0d kind %0d rel %0d last %0d, want key %0d kind %0d rel %0d last %0d",
							key_index, event_kind, released_event, last,
							want.ev.key, want.ev.kind, want.ev.rel, want.last));
				end
			end

			// predict events for each accepted scan tick
			if (in_valid && !in_stall) begin
				ticks_seen++;
				classify_tick(pressed_mask);
			end
		end
		outstanding = predicted_events.size();
	end

endmodule

[verif/multi_key_click_hold_classifier_tb.sv]
`timescale 1ns / 1ps

module multi_key_click_hold_classifier_tb;

	import mkc_pkg::*;

	localparam int PROGRESS_LIMIT = 1000;
	localparam int SETTLE_CYCLES  = 20;
	localparam int DRAIN_CYCLES   = 30;
	localparam int DIRECTED_COUNT = 27;
	// Scan ticks of the opening sequence, tick 0 in the lowest nibble
	localparam logic [4*DIRECTED_COUNT-1:0] DIRECTED_MASKS =
		108'h11111_9DEEC_C0010_2EEEE_E2FFF_FF;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [3:0]  pressed_mask;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  key_index;
	logic [2:0]  event_kind;
	logic [2:0]  released_event;
	logic        last;

	int          mismatches;
	int          outstanding;
	int          ticks_seen;
	int          events_seen;
	logic [7:0]  kinds_seen;

	logic        quiet;
	int          stall_left;
	int          cycles_since_progress = 0;
	int          settings_used;
	logic        key_level [KEY_COUNT];
	int          run_left [KEY_COUNT];
	logic [63:0] iv;
	logic [63:0] ho;
	logic [63:0] lo;

	multi_key_click_hold_classifier uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.pressed_mask   (pressed_mask),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.key_index      (key_index),
		.event_kind     (event_kind),
		.released_event (released_event),
		.last           (last)
	);

	mkc_event_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.pressed_mask   (pressed_mask),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.key_index      (key_index),
		.event_kind     (event_kind),
		.released_event (released_event),
		.last           (last),
		.mismatches     (mismatches),
		.outstanding    (outstanding),
		.ticks_seen     (ticks_seen),
		.events_seen    (events_seen),
		.kinds_seen     (kinds_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stall the event side in random bursts
	initial begin
		out_stall  = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left != 0) begin
				stall_left--;
				out_stall = 1'b1;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 2);
				out_stall  = 1'b1;
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	// End the run when no request moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			cycles_since_progress <= 0;
		else
			cycles_since_progress <= cycles_since_progress + 1;
		if (cycles_since_progress >= PROGRESS_LIMIT) begin
			$display("Timeout: no request moved for %0d cycles", PROGRESS_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	// Load all four registers; upper bits of the release write are junk
	task automatic apply_settings(input logic [63:0] intervals, input logic [63:0] holds,
			input logic [63:0] longs, input logic [3:0] rel_en);
		write_reg(CFG_INTERVAL, intervals);
		write_reg(CFG_HOLD, holds);
		write_reg(CFG_LONG, longs);
		write_reg(CFG_RELEASE, {$urandom(), 28'($urandom()), rel_en});
		settings_used++;
	endtask

	// Offer one scan tick, with an optional idle gap, and hold it until taken
	task automatic send_tick(input logic [3:0] m);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		in_valid     = 1'b1;
		pressed_mask = m;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Drain all predicted events, then let the scan finish
	task automatic settle();
		in_valid = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Drive keys as runs of press and release: bounces, clicks and long holds
	task automatic random_ticks(input int count);
		logic [3:0] m;
		int pick;
		for (int i = 0; i < count; i++) begin
			for (int k = 0; k < KEY_COUNT; k++) begin
				if (run_left[k] == 0) begin
					key_level[k] = !key_level[k];
					pick = $urandom_range(0, 9);
					if (key_level[k])
						run_left[k] = (pick < 2) ? $urandom_range(1, 3) :
							(pick < 7) ? $urandom_range(5, 8) : $urandom_range(9, 45);
					else
						run_left[k] = (pick < 4) ? $urandom_range(1, 4) :
							(pick < 7) ? $urandom_range(5, 8) : $urandom_range(9, 20);
				end
				run_left[k]--;
				m[k] = key_level[k];
			end
			// occasional single-tick glitch on one key
			if ($urandom_range(0, 9) == 0)
				m = m ^ (4'b0001 << $urandom_range(0, 3));
			send_tick(m);
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_INTERVAL;
		cfg_data      = '0;
		in_valid      = 1'b0;
		pressed_mask  = '0;
		quiet         = 1'b0;
		settings_used = 0;
		for (int k = 0; k < KEY_COUNT; k++) begin
			key_level[k] = 1'b0;
			run_left[k]  = 0;
		end
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Opening sequence: key 0 with thresholds off gives a single click,
		// key 1 with zero hold and a long threshold gives hold then long and
		// keeps its pending event with release reports off, key 2 builds a
		// triple click, key 3 gives a double click and then a hold.
		apply_settings(64'h0003_0005_0004_0006, 64'h0006_0014_0000_0000,
			64'h0000_0000_000A_0000, 4'b1101);
		for (int i = 0; i < DIRECTED_COUNT; i++)
			send_tick(DIRECTED_MASKS[4*i +: 4]);

		// all registers at zero
		settle();
		apply_settings('0, '0, '0, 4'h0);
		random_ticks(40);

		// all registers at full scale: thresholds and gaps never reached
		settle();
		apply_settings('1, '1, '1, 4'hF);
		random_ticks(30);

		// random per-key settings; the last phase runs without idling
		for (int p = 0; p < 4; p++) begin
			for (int k = 0; k < KEY_COUNT; k++) begin
				iv[16*k +: 16] = ($urandom_range(0, 7) == 0) ?
					16'($urandom_range(0, 40)) : 16'($urandom_range(1, 12));
				ho[16*k +: 16] = ($urandom_range(0, 3) == 0) ? '0 : 16'($urandom_range(6, 30));
				lo[16*k +: 16] = ($urandom_range(0, 2) == 0) ?
					'0 : ho[16*k +: 16] + 16'($urandom_range(4, 30));
			end
			settle();
			if (p == 3)
				quiet = 1'b1;
			apply_settings(iv, ho, lo, 4'($urandom()));
			random_ticks(50);
		end

		in_valid = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Scanned %0d ticks under %0d register settings, %0d events checked.",
			ticks_seen, settings_used, events_seen);
		$display("Event kinds seen (release down to hold): %b", kinds_seen[5:0]);
		if (mismatches == 0 && outstanding == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
